[rtl/core/psw_pkg.sv]
// ----------------------------------------------------------------------------
// psw_pkg
// shared constants and types of the priority schedule wait time unit
// ----------------------------------------------------------------------------
`default_nettype none
package psw_pkg;
  localparam int MAX_PROCS_DEF = 32;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int ID_W    = 6;
  localparam int TIME_W  = 21;

  // command word from controller to datapath
  typedef struct packed {
    logic load;       // store the input word at the fill count
    logic sel_init;   // best = i, j = i + 1
    logic sel_step;   // compare entry j against best, advance j
    logic swap;       // exchange entries i and best, advance i
    logic out_init;   // clear running sums, k = 0
    logic out_step;   // emit result k, advance k
    logic div_init;   // start the averaging division
    logic div_step;   // one quotient bit
    logic finish;     // clear batch state
  } psw_cmd_t;

  // status word from datapath to controller
  typedef struct packed {
    logic empty;      // no process stored
    logic sel_done;   // j reached count
    logic sort_done;  // i reached count
    logic out_last;   // k is the last entry
    logic div_done;   // all quotient bits done
  } psw_sts_t;
endpackage
`default_nettype wire

[rtl/core/psw_ctrl.sv]
// ----------------------------------------------------------------------------
// psw_ctrl
// sequencer: load, selection sort, result emission, averaging division
// ----------------------------------------------------------------------------
`default_nettype none
module psw_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              in_last_process,
  input  wire psw_pkg::psw_sts_t sts,
  output logic                   busy,
  output psw_pkg::psw_cmd_t      cmd
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SINI = 7'b0000010,
    S_SCAN = 7'b0000100,
    S_SWAP = 7'b0001000,
    S_EMIT = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_LAST = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_last_process) state_nxt = S_SINI;
        end
      end
      S_SINI: begin
        if (sts.empty) begin
          cmd.finish = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.sort_done) begin
          cmd.out_init = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          cmd.sel_init = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.sel_done) state_nxt = S_SWAP;
        else cmd.sel_step = 1'b1;
      end
      S_SWAP: begin
        cmd.swap = 1'b1;
        state_nxt = S_SINI;
      end
      S_EMIT: begin
        if (sts.out_last) begin
          cmd.div_init = 1'b1;
          state_nxt = S_DIV;
        end else begin
          cmd.out_step = 1'b1;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_LAST;
        else cmd.div_step = 1'b1;
      end
      S_LAST: begin
        cmd.out_step = 1'b1;
        cmd.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[rtl/core/psw_dp.sv]
// ----------------------------------------------------------------------------
// psw_dp
// process store, sort indexes, running sums and restoring divider
// ----------------------------------------------------------------------------
`default_nettype none
module psw_dp #(
  parameter int MAX_PROCS = psw_pkg::MAX_PROCS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire psw_pkg::psw_cmd_t            cmd,
  input  wire logic [psw_pkg::BURST_W-1:0]  in_burst_time,
  input  wire logic [psw_pkg::PRIO_W-1:0]   in_priority_req,
  output psw_pkg::psw_sts_t                 sts,
  output logic                              out_valid,
  output logic [psw_pkg::ID_W-1:0]          out_process_id,
  output logic [psw_pkg::BURST_W-1:0]       out_burst_out,
  output logic [psw_pkg::TIME_W-1:0]        out_wait_time,
  output logic [psw_pkg::TIME_W-1:0]        out_turnaround_time,
  output logic [psw_pkg::TIME_W-1:0]        out_avg_wait,
  output logic [psw_pkg::TIME_W-1:0]        out_avg_turnaround,
  output logic                              out_overflow,
  output logic                              out_last_result
);
  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int BW = psw_pkg::BURST_W;
  localparam int PW = psw_pkg::PRIO_W;
  localparam int DW = psw_pkg::ID_W;
  localparam int TW = psw_pkg::TIME_W;
  // running wait holds the full sum of bursts, never less than the field
  localparam int WW = (BW + CW > TW) ? BW + CW : TW;
  localparam int SW = WW + CW;                 // sum width
  localparam int DCW = $clog2(SW + 1);         // divider step counter width

  // entries are small register arrays read at a few control-chosen indexes
  logic [BW-1:0] burst_r [MAX_PROCS];
  logic [PW-1:0] prio_r  [MAX_PROCS];
  logic [DW-1:0] id_r    [MAX_PROCS];
  logic [CW-1:0] count_r, i_r, j_r, best_r, k_r;
  logic [DCW-1:0] dcnt_r;
  logic          ovf_r;
  logic [WW-1:0] wait_r;
  logic [SW-1:0] swait_r, stat_r;
  logic [SW-1:0] qw_r, qt_r, rw_r, rt_r;

  logic [IW-1:0] ii, ij, ib, ik, ic;
  assign ii = i_r[IW-1:0];
  assign ij = j_r[IW-1:0];
  assign ib = best_r[IW-1:0];
  assign ik = k_r[IW-1:0];
  assign ic = count_r[IW-1:0];

  logic [WW-1:0] tat;
  assign tat = wait_r + WW'(burst_r[ik]);

  // status
  assign sts.empty     = (count_r == '0);
  assign sts.sel_done  = (j_r >= count_r);
  assign sts.sort_done = (i_r >= count_r);
  assign sts.out_last  = (k_r == count_r - CW'(1));
  assign sts.div_done  = (dcnt_r == '0);

  // restoring division, one quotient bit per cycle for both sums
  logic [SW-1:0] rw_sh, rt_sh;
  assign rw_sh = {rw_r[SW-2:0], qw_r[SW-1]};
  assign rt_sh = {rt_r[SW-2:0], qt_r[SW-1]};

  // store writes at the fill count, swaps at i and best
  always_ff @(posedge clk) begin
    if (cmd.load && count_r < CW'(MAX_PROCS)) begin
      burst_r[ic] <= in_burst_time;
      prio_r[ic]  <= in_priority_req;
      id_r[ic]    <= DW'(count_r + CW'(1));
    end
    if (cmd.swap) begin
      burst_r[ii] <= burst_r[ib];  burst_r[ib] <= burst_r[ii];
      prio_r[ii]  <= prio_r[ib];   prio_r[ib]  <= prio_r[ii];
      id_r[ii]    <= id_r[ib];     id_r[ib]    <= id_r[ii];
    end
  end

  // control counters, i stays at zero until the sort runs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0; ovf_r <= 1'b0; i_r <= '0; k_r <= '0; dcnt_r <= '0;
    end else begin
      if (cmd.load) begin
        if (count_r < CW'(MAX_PROCS)) count_r <= count_r + CW'(1);
        else ovf_r <= 1'b1;
      end
      if (cmd.swap) i_r <= i_r + CW'(1);
      if (cmd.out_init) k_r <= '0;
      if (cmd.out_step) k_r <= k_r + CW'(1);
      if (cmd.div_init) dcnt_r <= DCW'(SW);
      if (cmd.div_step) dcnt_r <= dcnt_r - DCW'(1);
      if (cmd.finish) begin
        count_r <= '0; ovf_r <= 1'b0; i_r <= '0;
      end
    end
  end

  // sort scan registers
  always_ff @(posedge clk) begin
    if (cmd.sel_init) begin
      best_r <= i_r;
      j_r <= i_r + CW'(1);
    end
    if (cmd.sel_step) begin
      if (prio_r[ij] < prio_r[ib]) best_r <= j_r;
      j_r <= j_r + CW'(1);
    end
  end

  // sweep: wait sums and division
  always_ff @(posedge clk) begin
    if (cmd.out_init) begin
      wait_r <= '0; swait_r <= '0; stat_r <= '0;
    end
    if (cmd.out_step) begin
      wait_r  <= tat;
      swait_r <= swait_r + SW'(wait_r);
      stat_r  <= stat_r + SW'(tat);
    end
    if (cmd.div_init) begin
      qw_r <= swait_r + SW'(wait_r);
      qt_r <= stat_r + SW'(tat);
      rw_r <= '0; rt_r <= '0;
    end
    if (cmd.div_step) begin
      if (rw_sh >= SW'(count_r)) begin
        rw_r <= rw_sh - SW'(count_r); qw_r <= {qw_r[SW-2:0], 1'b1};
      end else begin
        rw_r <= rw_sh; qw_r <= {qw_r[SW-2:0], 1'b0};
      end
      if (rt_sh >= SW'(count_r)) begin
        rt_r <= rt_sh - SW'(count_r); qt_r <= {qt_r[SW-2:0], 1'b1};
      end else begin
        rt_r <= rt_sh; qt_r <= {qt_r[SW-2:0], 1'b0};
      end
    end
  end

  // result outputs, combinational from the sweep index
  assign out_valid           = cmd.out_step;
  assign out_process_id      = id_r[ik];
  assign out_burst_out       = burst_r[ik];
  assign out_wait_time       = wait_r[TW-1:0];
  assign out_turnaround_time = tat[TW-1:0];
  assign out_last_result     = cmd.finish && !sts.empty;
  assign out_avg_wait        = out_last_result ? qw_r[TW-1:0] : '0;
  assign out_avg_turnaround  = out_last_result ? qt_r[TW-1:0] : '0;
  assign out_overflow        = ovf_r;
endmodule
`default_nettype wire

[rtl/core/priority_schedule_wait_times_unit.sv]
// ----------------------------------------------------------------------------
// priority_schedule_wait_times_unit
// non-preemptive priority scheduler with waiting and turnaround times
// ----------------------------------------------------------------------------
// A process word is taken on start while busy is low. On a word marked
// last the block raises busy and selection-sorts the batch of n processes
// (for each position a setup, one compare per cycle and a swap), then
// emits one result per cycle on out_valid; before the final result a
// restoring divider works out both averages side by side, 28 quotient
// bits each. The receiver cannot stall: each result is shown for exactly
// one cycle.
`default_nettype none
module priority_schedule_wait_times_unit #(
  parameter int MAX_PROCS = psw_pkg::MAX_PROCS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [psw_pkg::BURST_W-1:0]  in_burst_time,
  input  wire logic [psw_pkg::PRIO_W-1:0]   in_priority_req,
  input  wire logic                         in_last_process,
  output logic                              out_valid,
  output logic [psw_pkg::ID_W-1:0]          out_process_id,
  output logic [psw_pkg::BURST_W-1:0]       out_burst_out,
  output logic [psw_pkg::TIME_W-1:0]        out_wait_time,
  output logic [psw_pkg::TIME_W-1:0]        out_turnaround_time,
  output logic [psw_pkg::TIME_W-1:0]        out_avg_wait,
  output logic [psw_pkg::TIME_W-1:0]        out_avg_turnaround,
  output logic                              out_overflow,
  output logic                              out_last_result
);
  psw_pkg::psw_cmd_t cmd;
  psw_pkg::psw_sts_t sts;

  psw_ctrl u_ctrl (
    .clk, .rst_n, .start, .in_last_process, .sts, .busy, .cmd
  );

  psw_dp #(.MAX_PROCS(MAX_PROCS)) u_dp (
    .clk, .rst_n, .cmd, .in_burst_time, .in_priority_req, .sts,
    .out_valid, .out_process_id, .out_burst_out, .out_wait_time,
    .out_turnaround_time, .out_avg_wait, .out_avg_turnaround,
    .out_overflow, .out_last_result
  );
endmodule
`default_nettype wire

[rtl/core/psw_checker.sv]
// ----------------------------------------------------------------------------
// psw_checker
// port-level checks of the scheduler, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
module psw_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         busy,
  input wire logic                         out_valid,
  input wire logic                         out_last_result,
  input wire logic [psw_pkg::BURST_W-1:0]  out_burst_out,
  input wire logic [psw_pkg::TIME_W-1:0]   out_wait_time,
  input wire logic [psw_pkg::TIME_W-1:0]   out_turnaround_time,
  input wire logic [psw_pkg::TIME_W-1:0]   out_avg_wait
);
  // results only while busy
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  // last result ends the batch
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |=> !busy) else $error("busy after last");
  // averages zero except on last
  a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |-> out_avg_wait == '0)
    else $error("average on non-last result");
  // turnaround is wait plus own burst
  a_tat_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_turnaround_time ==
      psw_pkg::TIME_W'(out_wait_time + psw_pkg::TIME_W'(out_burst_out)))
    else $error("turnaround sum");
  // turnaround chains into next wait
  a_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |=> !out_valid ||
      out_wait_time == $past(out_turnaround_time)) else $error("wait chain");
endmodule

bind priority_schedule_wait_times_unit psw_checker u_psw_checker (
  .clk, .rst_n, .busy, .out_valid, .out_last_result, .out_burst_out,
  .out_wait_time, .out_turnaround_time, .out_avg_wait
);
`default_nettype wire
